[rtl/atc_pkg.sv]
// Shared types, constants and table builder for the affine TRS compose block.
`timescale 1ns / 1ps
`default_nettype none
package atc_pkg;

  // Pipeline depth in register stages
  localparam int NUM_STAGES = 7;

  // pi/2 in Q2.30
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // One turn is 360 * 2^16 = 45 * 2^19
  localparam int TURN_SHIFT = 19;
  localparam int TURN_ODD   = 45;

  // Reciprocal of 45 for 13-bit values: ceil(2^19 / 45)
  localparam int unsigned RECIP45_SMALL = 11651;

  // Half a turn in Q16.16
  localparam int unsigned HALF_TURN_Q16 = 11796480;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] angle_deg;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic               has_parent;
    logic signed [31:0] parent_a;
    logic signed [31:0] parent_b;
    logic signed [31:0] parent_c;
    logic signed [31:0] parent_d;
    logic signed [31:0] parent_tx;
    logic signed [31:0] parent_ty;
  } xform_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } mat_t;

  // Per-stage load enables, stage 1 at bit 1
  typedef struct packed {
    logic [NUM_STAGES:1] load;
  } pipe_ctl_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -67'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Quarter-wave sine entry in Q1.16, built by a Taylor series in Q30
  function automatic logic [16:0] quarter_sine(input longint unsigned idx,
                                               input int unsigned bits);
    longint unsigned n;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned r;
    n = 64'd1 << bits;
    x = (PI_HALF_Q30 * idx + (n >> 1)) >> bits;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    // Alternate the series terms, divisor (2k)(2k+1) for k = 1..8
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd272;
    sum = sum + term;
    r = (sum + 64'd8192) >> 14;
    if (r > 64'd65536) begin
      r = 64'd65536;
    end
    return r[16:0];
  endfunction

endpackage
`default_nettype wire

[rtl/atc_if.sv]
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface atc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] angle_deg;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;
  logic               has_parent;
  logic signed [31:0] parent_a;
  logic signed [31:0] parent_b;
  logic signed [31:0] parent_c;
  logic signed [31:0] parent_d;
  logic signed [31:0] parent_tx;
  logic signed [31:0] parent_ty;

  modport source (
    output valid, pos_x, pos_y, angle_deg, scale_x, scale_y, has_parent,
           parent_a, parent_b, parent_c, parent_d, parent_tx, parent_ty,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, angle_deg, scale_x, scale_y, has_parent,
           parent_a, parent_b, parent_c, parent_d, parent_tx, parent_ty,
    output ready
  );
endinterface

interface atc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] local_a;
  logic signed [31:0] local_b;
  logic signed [31:0] local_c;
  logic signed [31:0] local_d;
  logic signed [31:0] local_tx;
  logic signed [31:0] local_ty;
  logic signed [31:0] global_a;
  logic signed [31:0] global_b;
  logic signed [31:0] global_c;
  logic signed [31:0] global_d;
  logic signed [31:0] global_tx;
  logic signed [31:0] global_ty;

  modport source (
    output valid, local_a, local_b, local_c, local_d, local_tx, local_ty,
           global_a, global_b, global_c, global_d, global_tx, global_ty,
    input  ready
  );
  modport sink (
    input  valid, local_a, local_b, local_c, local_d, local_tx, local_ty,
           global_a, global_b, global_c, global_d, global_tx, global_ty,
    output ready
  );
endinterface
`default_nettype wire

[rtl/atc_phase.sv]
// Angle reduction modulo 360 degrees and quantization to a table phase.
`timescale 1ns / 1ps
`default_nettype none
module atc_phase #(
  parameter int TABLE_BITS = 10
) (
  input  wire logic               clk,
  input  wire atc_pkg::pipe_ctl_t ctl,
  input  wire logic signed [31:0] angle,
  output logic [TABLE_BITS+1:0]   phase
);

  localparam int RK    = TABLE_BITS + 14;
  localparam int RW    = TABLE_BITS + 9;
  localparam int VW    = TABLE_BITS + 28;
  localparam int WW    = VW - atc_pkg::TURN_SHIFT;
  localparam longint unsigned RECIP =
    ((64'd1 << RK) + longint'(atc_pkg::TURN_ODD - 1)) / longint'(atc_pkg::TURN_ODD);

  // Stage 1: offset binary, remainder of the top bits by 45, undo the offset
  logic [31:0] ubin;
  logic [12:0] top;
  logic [26:0] qprod;
  logic [7:0]  quo;
  logic [12:0] rem13;
  logic [5:0]  rem;
  logic [5:0]  rem_adj;
  logic [24:0] turn_pos;

  always_comb begin
    ubin    = {~angle[31], angle[30:0]};
    top     = ubin[31:19];
    qprod   = 27'(top) * 27'(atc_pkg::RECIP45_SMALL);
    quo     = qprod[26:19];
    rem13   = top - 13'(quo) * 13'(atc_pkg::TURN_ODD);
    rem     = rem13[5:0];
    rem_adj = (rem == 6'd0) ? 6'(atc_pkg::TURN_ODD - 1) : rem - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      turn_pos <= {rem_adj, ubin[18:0]};
    end
  end

  // Stage 2: phase = floor((m * 4N + half turn) / turn)
  logic [VW-1:0]   scaled;
  logic [WW-1:0]   hi;
  logic [WW+RW-1:0] pprod;

  always_comb begin
    scaled = (VW'(turn_pos) << (TABLE_BITS + 2)) + VW'(atc_pkg::HALF_TURN_Q16);
    hi     = scaled[VW-1:atc_pkg::TURN_SHIFT];
    pprod  = (WW+RW)'(hi) * (WW+RW)'(RECIP[RW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      phase <= pprod[RK+TABLE_BITS+1:RK];
    end
  end

endmodule
`default_nettype wire

[rtl/atc_sincos.sv]
// Quarter-wave sine table and quadrant folding into sine and cosine.
`timescale 1ns / 1ps
`default_nettype none
module atc_sincos #(
  parameter int TABLE_BITS = 10
) (
  input  wire logic               clk,
  input  wire atc_pkg::pipe_ctl_t ctl,
  input  wire logic [TABLE_BITS+1:0] phase,
  output logic signed [17:0]      sin_v,
  output logic signed [17:0]      cos_v
);

  localparam int N = 1 << TABLE_BITS;

  // Constant quarter-wave table, N+1 entries
  logic [16:0] rom [0:N];

  for (genvar g = 0; g <= N; g++) begin : g_rom
    localparam logic [16:0] ENTRY = atc_pkg::quarter_sine(longint'(g), TABLE_BITS);
    assign rom[g] = ENTRY;
  end

  logic [1:0]            quad;
  logic [TABLE_BITS:0]   idx;
  logic [TABLE_BITS:0]   idx_rev;
  logic [1:0]            quad_r;
  logic [16:0]           t_fwd_r;
  logic [16:0]           t_rev_r;
  logic signed [17:0]    t_fwd;
  logic signed [17:0]    t_rev;

  // Split the phase into quadrant, forward and reversed table index
  always_comb begin
    quad    = phase[TABLE_BITS+1:TABLE_BITS];
    idx     = {1'b0, phase[TABLE_BITS-1:0]};
    idx_rev = (TABLE_BITS+1)'(N) - idx;
  end

  // Stage 3: registered table reads at two addresses
  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      t_fwd_r <= rom[idx];
      t_rev_r <= rom[idx_rev];
      quad_r  <= quad;
    end
  end

  // Fold the quadrant onto the forward and reversed table reads
  always_comb begin
    t_fwd = $signed({1'b0, t_fwd_r});
    t_rev = $signed({1'b0, t_rev_r});
    case (quad_r)
      2'd0: begin
        sin_v = t_fwd;
        cos_v = t_rev;
      end
      2'd1: begin
        sin_v = t_rev;
        cos_v = -t_fwd;
      end
      2'd2: begin
        sin_v = -t_fwd;
        cos_v = -t_rev;
      end
      default: begin
        sin_v = -t_rev;
        cos_v = t_fwd;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/atc_local.sv]
// Local matrix: rotation times scale products, rounded and saturated.
`timescale 1ns / 1ps
`default_nettype none
module atc_local (
  input  wire logic               clk,
  input  wire atc_pkg::pipe_ctl_t ctl,
  input  wire logic signed [17:0] sin_v,
  input  wire logic signed [17:0] cos_v,
  input  wire atc_pkg::xform_t    item,
  output atc_pkg::mat_t           loc
);

  // Stage 4: four products
  logic signed [49:0] p_a;
  logic signed [49:0] p_b;
  logic signed [49:0] p_c;
  logic signed [49:0] p_d;
  logic signed [31:0] tx4;
  logic signed [31:0] ty4;
  logic signed [17:0] nsin;

  assign nsin = -sin_v;

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      p_a <= 50'(cos_v) * 50'(item.scale_x);
      p_b <= 50'(sin_v) * 50'(item.scale_x);
      p_c <= 50'(nsin) * 50'(item.scale_y);
      p_d <= 50'(cos_v) * 50'(item.scale_y);
      tx4 <= item.pos_x;
      ty4 <= item.pos_y;
    end
  end

  // Stage 5: round to Q16.16 and clamp
  function automatic logic signed [31:0] rnd(input logic signed [49:0] p);
    logic signed [66:0] v;
    v = (67'(p) + 67'sd32768) >>> 16;
    return atc_pkg::sat32(v);
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      loc.a  <= rnd(p_a);
      loc.b  <= rnd(p_b);
      loc.c  <= rnd(p_c);
      loc.d  <= rnd(p_d);
      loc.tx <= tx4;
      loc.ty <= ty4;
    end
  end

endmodule
`default_nettype wire

[rtl/atc_global.sv]
// Global matrix: parent times local, one rounding per element.
`timescale 1ns / 1ps
`default_nettype none
module atc_global (
  input  wire logic               clk,
  input  wire atc_pkg::pipe_ctl_t ctl,
  input  wire atc_pkg::xform_t    item,
  input  wire atc_pkg::mat_t      loc,
  output atc_pkg::mat_t           loc_out,
  output atc_pkg::mat_t           glob
);

  // Stage 6: twelve products
  logic signed [63:0] m_aa, m_ca, m_ba, m_da;
  logic signed [63:0] m_ac, m_cc, m_bc, m_dc;
  logic signed [63:0] m_at, m_ct, m_bt, m_dt;
  logic signed [31:0] ptx6;
  logic signed [31:0] pty6;
  logic               par6;
  atc_pkg::mat_t      loc6;

  always_ff @(posedge clk) begin
    if (ctl.load[6]) begin
      m_aa <= 64'(item.parent_a) * 64'(loc.a);
      m_ca <= 64'(item.parent_c) * 64'(loc.b);
      m_ba <= 64'(item.parent_b) * 64'(loc.a);
      m_da <= 64'(item.parent_d) * 64'(loc.b);
      m_ac <= 64'(item.parent_a) * 64'(loc.c);
      m_cc <= 64'(item.parent_c) * 64'(loc.d);
      m_bc <= 64'(item.parent_b) * 64'(loc.c);
      m_dc <= 64'(item.parent_d) * 64'(loc.d);
      m_at <= 64'(item.parent_a) * 64'(loc.tx);
      m_ct <= 64'(item.parent_c) * 64'(loc.ty);
      m_bt <= 64'(item.parent_b) * 64'(loc.tx);
      m_dt <= 64'(item.parent_d) * 64'(loc.ty);
      ptx6 <= item.parent_tx;
      pty6 <= item.parent_ty;
      par6 <= item.has_parent;
      loc6 <= loc;
    end
  end

  // Sum exactly with the translation, round once, clamp
  function automatic logic signed [31:0] dot(input logic signed [63:0] p1,
                                             input logic signed [63:0] p2,
                                             input logic signed [31:0] t);
    logic signed [66:0] v;
    v = (67'(p1) + 67'(p2) + (67'(t) <<< 16) + 67'sd32768) >>> 16;
    return atc_pkg::sat32(v);
  endfunction

  // Stage 7: output register
  always_ff @(posedge clk) begin
    if (ctl.load[7]) begin
      loc_out <= loc6;
      if (par6) begin
        glob.a  <= dot(m_aa, m_ca, 32'sd0);
        glob.b  <= dot(m_ba, m_da, 32'sd0);
        glob.c  <= dot(m_ac, m_cc, 32'sd0);
        glob.d  <= dot(m_bc, m_dc, 32'sd0);
        glob.tx <= dot(m_at, m_ct, ptx6);
        glob.ty <= dot(m_bt, m_dt, pty6);
      end else begin
        glob <= loc6;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/affine_trs_transform_compose_core.sv]
// Top level of the affine TRS transform compose block.
// An accepted item runs through the phase, table, local and global stages to the output register.
// Throughput: one item per cycle; a stage only holds while the stage after it is full
// and stalled, so bubbles close up before the output back-pressure reaches the input.
// Reset (rst, synchronous, active high) clears all stage valid bits; no table clearing.
`timescale 1ns / 1ps
`default_nettype none
module affine_trs_transform_compose_core #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic  clk,
  input  wire logic  rst,
  atc_in_if.sink     xform,
  atc_out_if.source  result
);

  localparam int NS = atc_pkg::NUM_STAGES;

  atc_pkg::pipe_ctl_t ctl;
  logic [NS:1]        vld;
  atc_pkg::xform_t    item_in;
  atc_pkg::xform_t    items [1:5];

  // Load a stage when it is empty or the next one moves
  always_comb begin
    ctl.load[NS] = !vld[NS] || result.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      ctl.load[k] = !vld[k] || ctl.load[k+1];
    end
  end

  assign xform.ready = ctl.load[1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ctl.load[1]) begin
        vld[1] <= xform.valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (ctl.load[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Pack the input item
  always_comb begin
    item_in.pos_x      = xform.pos_x;
    item_in.pos_y      = xform.pos_y;
    item_in.angle_deg  = xform.angle_deg;
    item_in.scale_x    = xform.scale_x;
    item_in.scale_y    = xform.scale_y;
    item_in.has_parent = xform.has_parent;
    item_in.parent_a   = xform.parent_a;
    item_in.parent_b   = xform.parent_b;
    item_in.parent_c   = xform.parent_c;
    item_in.parent_d   = xform.parent_d;
    item_in.parent_tx  = xform.parent_tx;
    item_in.parent_ty  = xform.parent_ty;
  end

  // Carry the item alongside the angle and local stages
  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      items[1] <= item_in;
    end
    for (int k = 2; k <= 5; k++) begin
      if (ctl.load[k]) begin
        items[k] <= items[k-1];
      end
    end
  end

  logic [SINE_TABLE_BITS+1:0] phase;
  logic signed [17:0]         sin_v;
  logic signed [17:0]         cos_v;
  atc_pkg::mat_t              loc5;
  atc_pkg::mat_t              loc7;
  atc_pkg::mat_t              glob7;

  atc_phase #(.TABLE_BITS(SINE_TABLE_BITS)) u_phase (
    .clk   (clk),
    .ctl   (ctl),
    .angle (xform.angle_deg),
    .phase (phase)
  );

  atc_sincos #(.TABLE_BITS(SINE_TABLE_BITS)) u_sincos (
    .clk   (clk),
    .ctl   (ctl),
    .phase (phase),
    .sin_v (sin_v),
    .cos_v (cos_v)
  );

  atc_local u_local (
    .clk   (clk),
    .ctl   (ctl),
    .sin_v (sin_v),
    .cos_v (cos_v),
    .item  (items[3]),
    .loc   (loc5)
  );

  atc_global u_global (
    .clk     (clk),
    .ctl     (ctl),
    .item    (items[5]),
    .loc     (loc5),
    .loc_out (loc7),
    .glob    (glob7)
  );

  // Drive the result channel from the output register
  always_comb begin
    result.valid     = vld[NS];
    result.local_a   = loc7.a;
    result.local_b   = loc7.b;
    result.local_c   = loc7.c;
    result.local_d   = loc7.d;
    result.local_tx  = loc7.tx;
    result.local_ty  = loc7.ty;
    result.global_a  = glob7.a;
    result.global_b  = glob7.b;
    result.global_c  = glob7.c;
    result.global_d  = glob7.d;
    result.global_tx = glob7.tx;
    result.global_ty = glob7.ty;
  end

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the affine TRS transform compose block.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int TABLE_BITS = 10;
  localparam int QN = 1 << TABLE_BITS;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic signed [31:0] f[12];
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned fail_count = 0;
  bit quiet_phase = 1'b0;
  int unsigned idle_count = 0;
  result_t expected_q[$];
  longint sine_quarter[QN + 1];

  atc_in_if xform ();
  atc_out_if result ();

  affine_trs_transform_compose_core #(.SINE_TABLE_BITS(TABLE_BITS)) u_dut (
    .clk(clk), .rst(rst), .xform(xform), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Build the quarter-wave table in Q1.16 with a Taylor series in Q30
  function automatic longint table_entry(longint unsigned i);
    longint unsigned x, x2, term, sum, r;
    x = (64'd1686629713 * i + QN / 2) >> TABLE_BITS;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    r = (sum + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return longint'(r);
  endfunction

  function automatic longint phase_to_sine(longint p);
    longint q, i;
    p = p & (4 * QN - 1);
    q = p / QN;
    i = p % QN;
    case (q)
      0: return sine_quarter[i];
      1: return sine_quarter[QN - i];
      2: return -sine_quarter[i];
      default: return -sine_quarter[QN - i];
    endcase
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Exact sum of products plus translation, rounded once
  function automatic logic signed [31:0] round_sum(longint a1, longint b1, longint a2,
                                                   longint b2, longint t);
    logic signed [127:0] acc;
    acc = 128'(a1) * 128'(b1) + 128'(a2) * 128'(b2) + (128'(t) <<< 16) + 128'sd32768;
    return clamp32(acc >>> 16);
  endfunction

  function automatic result_t compose_transform(atc_pkg::xform_t x);
    result_t r;
    longint m, p, s, c;
    m = longint'(x.angle_deg) % 23592960;
    if (m < 0) m += 23592960;
    p = (m * 4 * QN + 11796480) / 23592960;
    p = p & (4 * QN - 1);
    s = phase_to_sine(p);
    c = phase_to_sine(p + QN);
    r.f[0] = round_sum(c, x.scale_x, 0, 0, 0);
    r.f[1] = round_sum(s, x.scale_x, 0, 0, 0);
    r.f[2] = round_sum(-s, x.scale_y, 0, 0, 0);
    r.f[3] = round_sum(c, x.scale_y, 0, 0, 0);
    r.f[4] = x.pos_x;
    r.f[5] = x.pos_y;
    if (x.has_parent) begin
      r.f[6] = round_sum(x.parent_a, r.f[0], x.parent_c, r.f[1], 0);
      r.f[7] = round_sum(x.parent_b, r.f[0], x.parent_d, r.f[1], 0);
      r.f[8] = round_sum(x.parent_a, r.f[2], x.parent_c, r.f[3], 0);
      r.f[9] = round_sum(x.parent_b, r.f[2], x.parent_d, r.f[3], 0);
      r.f[10] = round_sum(x.parent_a, r.f[4], x.parent_c, r.f[5], x.parent_tx);
      r.f[11] = round_sum(x.parent_b, r.f[4], x.parent_d, r.f[5], x.parent_ty);
    end else begin
      for (int j = 0; j < 6; j++) r.f[6 + j] = r.f[j];
    end
    return r;
  endfunction

  function automatic bit idle_now();
    return !quiet_phase && ($urandom_range(99) < 22);
  endfunction

  function automatic string field_name(int j);
    string names[12] = '{"local_a", "local_b", "local_c", "local_d", "local_tx",
                         "local_ty", "global_a", "global_b", "global_c", "global_d",
                         "global_tx", "global_ty"};
    return names[j];
  endfunction

  initial begin
    xform.valid = 1'b0;
    xform.pos_x = '0; xform.pos_y = '0; xform.angle_deg = '0;
    xform.scale_x = '0; xform.scale_y = '0; xform.has_parent = 1'b0;
    xform.parent_a = '0; xform.parent_b = '0; xform.parent_c = '0;
    xform.parent_d = '0; xform.parent_tx = '0; xform.parent_ty = '0;
    result.ready = 1'b0;
  end

  // Send one item, idling at random before it
  task automatic send_xform(atc_pkg::xform_t x);
    while (idle_now()) begin
      xform.valid <= 1'b0;
      @(posedge clk);
    end
    xform.valid <= 1'b1;
    xform.pos_x <= x.pos_x; xform.pos_y <= x.pos_y; xform.angle_deg <= x.angle_deg;
    xform.scale_x <= x.scale_x; xform.scale_y <= x.scale_y;
    xform.has_parent <= x.has_parent;
    xform.parent_a <= x.parent_a; xform.parent_b <= x.parent_b;
    xform.parent_c <= x.parent_c; xform.parent_d <= x.parent_d;
    xform.parent_tx <= x.parent_tx; xform.parent_ty <= x.parent_ty;
    do @(posedge clk); while (!xform.ready);
    expected_q.push_back(compose_transform(x));
  endtask

  // Drive ready at random and check each result against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    logic signed [31:0] got[12];
    if (!rst && result.valid && result.ready) begin
      got = '{result.local_a, result.local_b, result.local_c, result.local_d,
              result.local_tx, result.local_ty, result.global_a, result.global_b,
              result.global_c, result.global_d, result.global_tx, result.global_ty};
      if (expected_q.size() == 0) begin
        $error("result with no prediction waiting");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        for (int j = 0; j < 12; j++) begin
          if (got[j] !== want.f[j]) begin
            $error("field %0s expected %0d got %0d", field_name(j), want.f[j], got[j]);
            fail_count++;
          end
        end
      end
    end
    result.ready <= rst ? 1'b0 : !idle_now();
  end

  // Watchdog on cycles without any accepted input item or result
  always @(posedge clk) begin
    if ((xform.valid && xform.ready) || (result.valid && result.ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] edge_value();
    case ($urandom_range(6))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 0;
      3: return 32'sh00010000;
      4: return 32'shffff0000;
      5: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic atc_pkg::xform_t random_xform(bit wild);
    atc_pkg::xform_t x;
    x.pos_x = wild ? edge_value() : $signed($urandom_range(65535 * 32)) - 32'sd1048560;
    x.pos_y = wild ? edge_value() : $signed($urandom_range(65535 * 32)) - 32'sd1048560;
    x.angle_deg = ($urandom_range(3) == 0) ? $urandom : $urandom_range(23592959);
    x.scale_x = wild ? edge_value() : $signed($urandom_range(65536 * 8)) - 32'sd262144;
    x.scale_y = wild ? edge_value() : $signed($urandom_range(65536 * 8)) - 32'sd262144;
    x.has_parent = 1'($urandom_range(1));
    x.parent_a = wild ? edge_value() : $signed($urandom_range(65536 * 4)) - 32'sd131072;
    x.parent_b = wild ? edge_value() : $signed($urandom_range(65536 * 4)) - 32'sd131072;
    x.parent_c = wild ? edge_value() : $signed($urandom_range(65536 * 4)) - 32'sd131072;
    x.parent_d = wild ? edge_value() : $signed($urandom_range(65536 * 4)) - 32'sd131072;
    x.parent_tx = wild ? edge_value() : $urandom;
    x.parent_ty = wild ? edge_value() : $urandom;
    return x;
  endfunction

  // Directed: extremes, exact quadrant angles, negative angles, no parent and overflow
  task automatic test_directed();
    atc_pkg::xform_t x;
    logic signed [31:0] angles[10] = '{0, 32'sd5898240, 32'sd11796480, 32'sd17694720,
      -32'sd5898240, 32'sd23592960, 32'sh80000000, 32'sh7fffffff, 32'sd2949120, -1};
    for (int k = 0; k < 10; k++) begin
      x = random_xform(1'b0);
      x.angle_deg = angles[k];
      x.has_parent = k[0];
      send_xform(x);
    end
    for (int k = 0; k < 8; k++) begin
      x.pos_x = k[0] ? 32'sh7fffffff : 32'sh80000000;
      x.pos_y = k[1] ? 32'sh80000000 : 32'sh7fffffff;
      x.angle_deg = angles[k];
      x.scale_x = k[1] ? 32'sh7fffffff : 32'sh80000000;
      x.scale_y = k[0] ? 32'sh80000000 : 32'sh7fffffff;
      x.has_parent = (k != 7);
      x.parent_a = k[2] ? 32'sh7fffffff : 32'sh80000000;
      x.parent_b = k[0] ? 32'sh80000000 : 32'sh7fffffff;
      x.parent_c = k[1] ? 32'sh7fffffff : 32'sh80000000;
      x.parent_d = k[2] ? 32'sh80000000 : 32'sh7fffffff;
      x.parent_tx = k[0] ? 32'sh7fffffff : 32'sh80000000;
      x.parent_ty = k[1] ? 32'sh80000000 : 32'sh7fffffff;
      send_xform(x);
    end
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) begin
      quiet_phase = (k >= count / 2) && (k < count / 2 + 150);
      send_xform(random_xform($urandom_range(4) == 0));
    end
    quiet_phase = 1'b0;
  endtask

  task automatic drain_results();
    xform.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (atc_pkg::NUM_STAGES + 10) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i <= QN; i++) sine_quarter[i] = table_entry(i);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1350);
    drain_results();
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
